// ----- rtl/spf_pkg.sv -----
// shared types and constants for the source address / port packet filter
package spf_pkg;

    // table size and derived counter widths
    localparam int TABLE_DEPTH = 64;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // field widths
    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int PROTO_W = 8;
    localparam int CMD_W   = 2;
    localparam int MODE_W  = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLASSIFY = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

    // filter modes
    localparam logic [MODE_W-1:0] MODE_WHITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BLACK = 2'd2;

    // filtered protocols
    localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

    // one table entry, also used as the search key
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
    } entry_t;

endpackage

// ----- rtl/src_ip_port_packet_filter.sv -----
// top level of the source address / port packet filter
//
// Commands are taken when start is high and busy is low. Append, clear,
// classify of a protocol other than TCP/UDP, and unused codes finish without
// a scan: the result strobe (done) rises the cycle after the command, and busy
// stays low, so another command can follow at once. A TCP/UDP classify
// searches the table by rippling a hit flag along a row of TABLE_DEPTH cells,
// one cell per cycle; its result shows once the flag has passed the last
// cell, and busy is high until that cycle. Each result is present for one
// cycle only and the receiver cannot stall it. New entries enter at the head
// of the row and push older ones along; the filter mode register may only be
// written while the block is idle.
module src_ip_port_packet_filter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [spf_pkg::CMD_W-1:0]     cmd,
    input  logic [spf_pkg::ADDR_W-1:0]    src_addr,
    input  logic [spf_pkg::PROTO_W-1:0]   proto_num,
    input  logic [spf_pkg::PORT_W-1:0]    src_port_num,
    input  logic                          cfg_we,
    input  logic [spf_pkg::MODE_W-1:0]    cfg_wdata,
    output logic                          done,
    output logic                          verdict,
    output logic                          matched,
    output logic                          status
);
    import spf_pkg::*;

    logic              busy_reg,    busy_next;
    logic [CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [MODE_W-1:0] mode_reg;
    entry_t            key_reg,     key_next;
    logic              done_reg,    done_next;
    logic              verdict_reg, verdict_next;
    logic              matched_reg, matched_next;
    logic              status_reg,  status_next;

    logic   accept;
    logic   is_filtered;
    logic   shift_en;
    entry_t new_entry;
    logic   scan_hit;

    entry_t cell_entry [TABLE_DEPTH+1];
    logic   cell_hit   [TABLE_DEPTH+1];

    assign accept      = start && !busy_reg;
    assign is_filtered = (proto_num == PROTO_TCP) || (proto_num == PROTO_UDP);
    assign shift_en    = accept && (cmd == CMD_APPEND) &&
                         (count_reg != CNT_W'(TABLE_DEPTH));
    assign new_entry   = '{addr: src_addr, port: src_port_num};

    // row of cells, head fed by the new entry and a clear hit flag
    assign cell_entry[0] = new_entry;
    assign cell_hit[0]   = 1'b0;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic entry_valid;

        // cells below the fill count hold live entries
        assign entry_valid = count_reg > CNT_W'(i);

        spf_cell u_cell (
            .clk         (clk),
            .shift_en    (shift_en),
            .entry_in    (cell_entry[i]),
            .search_key  (key_reg),
            .entry_valid (entry_valid),
            .hit_in      (cell_hit[i]),
            .entry_out   (cell_entry[i+1]),
            .hit_out     (cell_hit[i+1])
        );
    end

    assign scan_hit = cell_hit[TABLE_DEPTH];

    // command decode and scan control
    always_comb
    begin
        busy_next     = busy_reg;
        scan_cnt_next = scan_cnt_reg;
        count_next    = count_reg;
        key_next      = key_reg;
        done_next     = 1'b0;
        verdict_next  = 1'b0;
        matched_next  = 1'b0;
        status_next   = 1'b0;

        if (busy_reg)
        begin
            // scan in flight, result once the flag reached the tail
            if (scan_cnt_reg == CNT_W'(TABLE_DEPTH))
            begin
                busy_next    = 1'b0;
                done_next    = 1'b1;
                matched_next = scan_hit;
                if (mode_reg == MODE_WHITE)
                begin
                    verdict_next = !scan_hit;
                end
                else if (mode_reg == MODE_BLACK)
                begin
                    verdict_next = scan_hit;
                end
            end
            else
            begin
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
            end
        end
        else if (accept)
        begin
            unique case (cmd)
                CMD_CLASSIFY:
                begin
                    if (is_filtered)
                    begin
                        busy_next     = 1'b1;
                        scan_cnt_next = '0;
                        key_next      = new_entry;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
                CMD_APPEND:
                begin
                    done_next = 1'b1;
                    if (count_reg == CNT_W'(TABLE_DEPTH))
                    begin
                        status_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_CLEAR:
                begin
                    done_next  = 1'b1;
                    count_next = '0;
                end
                default:
                begin
                    done_next = 1'b1;
                end
            endcase
        end
    end

    // control state and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            scan_cnt_reg <= '0;
            count_reg    <= '0;
            mode_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            scan_cnt_reg <= scan_cnt_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        verdict_reg <= verdict_next;
        matched_reg <= matched_next;
        status_reg  <= status_next;
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign verdict = verdict_reg;
    assign matched = matched_reg;
    assign status  = status_reg;

endmodule

// ----- rtl/spf_cell.sv -----
// one table cell: holds an entry, shifts it on append, ripples the hit flag
module spf_cell (
    input  logic           clk,
    input  logic           shift_en,
    input  spf_pkg::entry_t entry_in,
    input  spf_pkg::entry_t search_key,
    input  logic           entry_valid,
    input  logic           hit_in,
    output spf_pkg::entry_t entry_out,
    output logic           hit_out
);
    import spf_pkg::*;

    entry_t entry_reg;
    logic   hit_reg;
    logic   local_match;

    // compare the held entry against the broadcast key
    assign local_match = entry_valid && (entry_reg == search_key);

    // entry shift on append and hit ripple toward the end of the row
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            entry_reg <= entry_in;
        end
        hit_reg <= hit_in | local_match;
    end

    assign entry_out = entry_reg;
    assign hit_out   = hit_reg;

endmodule

// ----- tb/tb_src_ip_port_packet_filter.sv -----
// testbench for the source address / port packet filter: table commands, classify and modes
`timescale 1ns / 100ps

module tb_src_ip_port_packet_filter;
    import spf_pkg::*;

    // codes the package leaves unnamed
    localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam int ITEMS_PER_PHASE = 330;
    localparam int NUM_PHASES      = 6;
    localparam int POOL_SIZE       = 16;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int MAX_PRINTS      = 50;

    // expected outcome of one command
    typedef struct packed {
        logic verdict;
        logic matched;
        logic status;
    } verdict_t;

    // mirror of the filter table and mode, with the outcomes still owed by the block
    class verdict_model;
        entry_t            rules [TABLE_DEPTH];
        int unsigned       rule_count;
        logic [MODE_W-1:0] filter_mode;
        verdict_t          owed_verdicts [$];

        function new();
            rule_count  = 0;
            filter_mode = MODE_OFF;
        endfunction

        function void set_mode(logic [MODE_W-1:0] m);
            filter_mode = m;
        endfunction

        // note an accepted command and work out what it must produce
        function void take_packet(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] a,
                                  logic [PROTO_W-1:0] p, logic [PORT_W-1:0] pt);
            verdict_t r;
            bit       hit;
            r   = '0;
            hit = 1'b0;
            case (c)
                CMD_CLASSIFY:
                begin
                    if (p == PROTO_TCP || p == PROTO_UDP)
                    begin
                        for (int k = 0; k < rule_count; k++)
                            if (rules[k].addr == a && rules[k].port == pt)
                                hit = 1'b1;
                        r.matched = hit;
                        if (filter_mode == MODE_WHITE)
                            r.verdict = !hit;
                        else if (filter_mode == MODE_BLACK)
                            r.verdict = hit;
                    end
                end
                CMD_APPEND:
                begin
                    if (rule_count >= TABLE_DEPTH)
                        r.status = 1'b1;
                    else
                    begin
                        rules[rule_count] = '{addr: a, port: pt};
                        rule_count++;
                    end
                end
                CMD_CLEAR:
                    rule_count = 0;
                default:
                    ;
            endcase
            owed_verdicts.push_back(r);
        endfunction

        function int pending();
            return owed_verdicts.size();
        endfunction

        // compare one result with the oldest owed outcome; empty string when it agrees
        function string check_verdict(logic v, logic m, logic s);
            verdict_t e;
            if (owed_verdicts.size() == 0)
                return $sformatf("result v/m/s %b%b%b with no transaction waiting", v, m, s);
            e = owed_verdicts.pop_front();
            if (v !== e.verdict || m !== e.matched || s !== e.status)
                return $sformatf("v/m/s got %b%b%b expected %b%b%b",
                                 v, m, s, e.verdict, e.matched, e.status);
            return "";
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [CMD_W-1:0]    cmd;
    logic [ADDR_W-1:0]   src_addr;
    logic [PROTO_W-1:0]  proto_num;
    logic [PORT_W-1:0]   src_port_num;
    logic                cfg_we;
    logic [MODE_W-1:0]   cfg_wdata;
    logic                done;
    logic                verdict;
    logic                matched;
    logic                status;

    verdict_model filter_model = new();
    entry_t       key_pool [POOL_SIZE];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    bit           no_idle        = 1'b0;
    string        check_msg;

    src_ip_port_packet_filter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .src_addr     (src_addr),
        .proto_num    (proto_num),
        .src_port_num (src_port_num),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .verdict      (verdict),
        .matched      (matched),
        .status       (status)
    );

    always #10 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_src_ip_port_packet_filter: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // result monitor: a strobed result is taken at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done !== 1'b0)
        begin
            check_msg = filter_model.check_verdict(verdict, matched, status);
            if (check_msg != "")
                report_mismatch(check_msg);
        end
    end

    // issue one command after a random gap and hold it until the block takes it
    task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
                            input logic [PROTO_W-1:0] p, input logic [PORT_W-1:0] pt);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        cmd          <= c;
        src_addr     <= a;
        proto_num    <= p;
        src_port_num <= pt;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        filter_model.take_packet(c, a, p, pt);
    endtask

    // stop sending and wait until every owed result has come
    task automatic drain();
        start <= 1'b0;
        while (filter_model.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // mode register write, only with the block idle
    task automatic write_mode(input logic [MODE_W-1:0] m);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        filter_model.set_mode(m);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [PROTO_W-1:0] pick_filtered_proto();
        return ($urandom_range(0, 1) != 0) ? PROTO_TCP : PROTO_UDP;
    endfunction

    // one random transaction; dense phases fill the table past its end
    task automatic random_item(input bit dense);
        int       r;
        int       app_lim;
        int       clr_lim;
        int       k;
        entry_t   key;
        logic [PROTO_W-1:0] p;
        r       = $urandom_range(0, 199);
        app_lim = dense ? 70 : 50;
        clr_lim = app_lim + (dense ? 1 : 5);
        k       = $urandom_range(0, POOL_SIZE - 1);
        key     = key_pool[k];
        if (r < app_lim)
        begin
            if ($urandom_range(0, 9) < 3)
                key = {$urandom, 16'($urandom)};
            send_cmd(CMD_APPEND, key.addr, 8'($urandom), key.port);
        end
        else if (r < clr_lim)
            send_cmd(CMD_CLEAR, $urandom, 8'($urandom), 16'($urandom));
        else if (r < clr_lim + 4)
            send_cmd(CMD_UNUSED, $urandom, 8'($urandom), 16'($urandom));
        else
        begin
            // mostly filtered protocols, pool keys, near misses and random keys
            p = ($urandom_range(0, 4) == 0) ? 8'($urandom) : pick_filtered_proto();
            r = $urandom_range(0, 99);
            if (r >= 65)
                key = {$urandom, 16'($urandom)};
            else if (r >= 50)
                key = key ^ (48'd1 << $urandom_range(0, 47));
            send_cmd(CMD_CLASSIFY, key.addr, p, key.port);
        end
    endtask

    logic [MODE_W-1:0] phase_modes [NUM_PHASES] =
        '{MODE_WHITE, MODE_BLACK, MODE_OFF, MODE_SPARE, MODE_BLACK, MODE_WHITE};

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = CMD_CLASSIFY;
        src_addr     = '0;
        proto_num    = '0;
        src_port_num = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = MODE_OFF;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, 16'($urandom)};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every command, lookups on an empty and a cleared table
        send_cmd(CMD_CLASSIFY, 32'h0, PROTO_TCP, 16'h0);
        send_cmd(CMD_APPEND, 32'h0, 8'h0, 16'h0);
        send_cmd(CMD_APPEND, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        send_cmd(CMD_CLASSIFY, 32'h0, PROTO_TCP, 16'h0);
        send_cmd(CMD_CLASSIFY, 32'hFFFF_FFFF, PROTO_UDP, 16'hFFFF);
        send_cmd(CMD_CLASSIFY, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        send_cmd(CMD_CLASSIFY, 32'h0, 8'h0, 16'h0);
        send_cmd(CMD_CLASSIFY, 32'hFFFF_FFFF, PROTO_TCP, 16'h0);
        send_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);

        write_mode(MODE_WHITE);
        send_cmd(CMD_CLASSIFY, 32'h0, PROTO_TCP, 16'h0);
        send_cmd(CMD_CLASSIFY, 32'h0, PROTO_UDP, 16'hFFFF);
        send_cmd(CMD_CLASSIFY, 32'h1234_5678, 8'h05, 16'h9ABC);

        write_mode(MODE_BLACK);
        send_cmd(CMD_CLASSIFY, 32'hFFFF_FFFF, PROTO_UDP, 16'hFFFF);
        send_cmd(CMD_CLASSIFY, 32'h0, PROTO_TCP, 16'h1);

        write_mode(MODE_SPARE);
        send_cmd(CMD_CLASSIFY, 32'h0, PROTO_TCP, 16'h0);

        write_mode(MODE_BLACK);
        send_cmd(CMD_CLEAR, 32'h0, 8'h0, 16'h0);
        send_cmd(CMD_CLASSIFY, 32'h0, PROTO_TCP, 16'h0);

        // fill the table, then one append too many
        for (int i = 0; i <= TABLE_DEPTH; i++)
            send_cmd(CMD_APPEND, 32'hC0A8_0000 + i, PROTO_TCP, 16'(i));
        send_cmd(CMD_CLASSIFY, 32'hC0A8_0000 + TABLE_DEPTH - 1, PROTO_TCP,
                 16'(TABLE_DEPTH - 1));
        send_cmd(CMD_CLASSIFY, 32'hC0A8_0000 + TABLE_DEPTH, PROTO_UDP, 16'(TABLE_DEPTH));
        send_cmd(CMD_CLEAR, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);

        // random phases, one mode each, some with idle-free stretches
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_mode(phase_modes[ph]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % 50 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                if (n == ITEMS_PER_PHASE / 2 && ph % 2 == 0)
                    drain();
                random_item(ph % 2 == 1);
            end
            no_idle = 1'b0;
        end

        // let the last search finish and catch any stray strobe
        drain();
        repeat (TABLE_DEPTH + 4) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_src_ip_port_packet_filter: PASS");
        else
            $display("tb_src_ip_port_packet_filter: FAIL");
        $finish;
    end

endmodule
